// ===== rtl/mmed_pkg.sv =====
package mmed_pkg;

    localparam int CTRL_AW    = 11;
    localparam int PROG_AW    = 4;
    localparam int DATA_W     = 8;
    localparam int NUM_CH     = 16;
    localparam int MAX_DATA   = 127;
    localparam logic [7:0] CACHE_RESET = 8'hFF;

    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_CTRL     = 8'hB0;
    localparam logic [7:0] ST_PROG     = 8'hC0;

    typedef enum logic [1:0] {
        KIND_CC       = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_NOTE_OFF = 2'd2,
        KIND_PROG     = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
        logic       three;
    } msg_t;

endpackage

// ===== rtl/mmed_if.sv =====
interface midi_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] channel;
    logic [7:0] number;
    logic [7:0] value;

    modport source (output valid, kind, channel, number, value, input ready);
    modport sink (input valid, kind, channel, number, value, output ready);
endinterface

interface midi_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;
    logic       last_byte;

    modport source (output valid, midi_byte, last_byte, input ready);
    modport sink (input valid, midi_byte, last_byte, output ready);
endinterface

// ===== rtl/mmed_ram.sv =====
module mmed_ram
    import mmed_pkg::*;
#(
    parameter int AW = PROG_AW,
    parameter int DW = DATA_W
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/mmed_lookup.sv =====
module mmed_lookup
    import mmed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [1:0] kind,
    input  logic [7:0] channel,
    input  logic [7:0] number,
    input  logic [7:0] value,
    output logic       msg_valid,
    input  logic       msg_ready,
    output msg_t       msg,
    output logic       clearing
);

    // clearing sweep
    logic               clearing_reg, clearing_next;
    logic [CTRL_AW-1:0] clr_reg, clr_next;

    // stage 1: item whose cache entry is being read
    logic               s1_valid_reg, s1_valid_next;
    kind_t              s1_kind_reg;
    logic [3:0]         s1_ch0_reg;
    logic [6:0]         s1_num_reg;
    logic [6:0]         s1_val_reg;
    logic               s1_keep_reg;
    logic               s1_fwd_reg;
    logic [7:0]         s1_fwd_data_reg;

    logic               accept;
    logic               ch_ok, num_ok, val_ok, keep;
    logic [3:0]         ch0;
    kind_t              in_kind;
    logic [CTRL_AW-1:0] ctrl_raddr;
    logic [CTRL_AW-1:0] s1_ctrl_addr;

    logic               ctrl_we, prog_we;
    logic [CTRL_AW-1:0] ctrl_waddr;
    logic [PROG_AW-1:0] prog_waddr;
    logic [7:0]         ctrl_wdata, prog_wdata;
    logic [7:0]         ctrl_rdata, prog_rdata;

    logic               s1_ctrl_wr, s1_prog_wr;
    logic               fwd_hit;
    logic [7:0]         fwd_data;
    logic [7:0]         cached;
    logic               send, s1_adv;

    assign in_kind    = kind_t'(kind);
    assign ch_ok      = (channel >= 8'd1) && (channel <= 8'(NUM_CH));
    assign num_ok     = number <= 8'(MAX_DATA);
    assign val_ok     = value <= 8'(MAX_DATA);
    assign keep       = ch_ok && num_ok && ((in_kind == KIND_PROG) || val_ok);
    assign ch0        = 4'(channel - 8'd1);
    assign ctrl_raddr = {ch0, number[6:0]};
    assign s1_ctrl_addr = {s1_ch0_reg, s1_num_reg};

    assign req_ready  = !clearing_reg && (!s1_valid_reg || s1_adv);
    assign accept     = req_valid && req_ready;
    assign clearing   = clearing_reg;

    // decide on the stage 1 item
    always_comb
    begin
        cached = s1_fwd_reg ? s1_fwd_data_reg
                            : ((s1_kind_reg == KIND_PROG) ? prog_rdata : ctrl_rdata);
        case (s1_kind_reg)
            KIND_CC:   send = s1_keep_reg && (cached != {1'b0, s1_val_reg});
            KIND_PROG: send = s1_keep_reg && (cached != {1'b0, s1_num_reg});
            default:   send = s1_keep_reg;
        endcase
    end

    always_comb
    begin
        case (s1_kind_reg)
            KIND_CC:      msg.status = ST_CTRL | {4'd0, s1_ch0_reg};
            KIND_PROG:    msg.status = ST_PROG | {4'd0, s1_ch0_reg};
            KIND_NOTE_ON: msg.status = ((s1_val_reg != 7'd0) ? ST_NOTE_ON : ST_NOTE_OFF)
                                       | {4'd0, s1_ch0_reg};
            default:      msg.status = ST_NOTE_OFF | {4'd0, s1_ch0_reg};
        endcase
        msg.data1 = {1'b0, s1_num_reg};
        msg.data2 = {1'b0, s1_val_reg};
        msg.three = s1_kind_reg != KIND_PROG;
    end

    assign msg_valid  = s1_valid_reg && send;
    assign s1_adv     = s1_valid_reg && (!send || msg_ready);
    assign s1_ctrl_wr = s1_adv && send && (s1_kind_reg == KIND_CC);
    assign s1_prog_wr = s1_adv && send && (s1_kind_reg == KIND_PROG);

    // forward the write that lands in the same cycle as the new read
    always_comb
    begin
        if (in_kind == KIND_PROG)
        begin
            fwd_hit  = s1_prog_wr && (s1_ch0_reg == ch0);
            fwd_data = {1'b0, s1_num_reg};
        end
        else
        begin
            fwd_hit  = s1_ctrl_wr && (s1_ctrl_addr == ctrl_raddr);
            fwd_data = {1'b0, s1_val_reg};
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            ctrl_we    = 1'b1;
            ctrl_waddr = clr_reg;
            ctrl_wdata = CACHE_RESET;
            prog_we    = 1'b1;
            prog_waddr = clr_reg[PROG_AW-1:0];
            prog_wdata = CACHE_RESET;
        end
        else
        begin
            ctrl_we    = s1_ctrl_wr;
            ctrl_waddr = s1_ctrl_addr;
            ctrl_wdata = {1'b0, s1_val_reg};
            prog_we    = s1_prog_wr;
            prog_waddr = s1_ch0_reg;
            prog_wdata = {1'b0, s1_num_reg};
        end
    end

    always_comb
    begin
        clr_next      = clr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_next = clr_reg + 1'b1;
            if (clr_reg == {CTRL_AW{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
        s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_reg      <= clr_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg     <= in_kind;
            s1_ch0_reg      <= ch0;
            s1_num_reg      <= number[6:0];
            s1_val_reg      <= value[6:0];
            s1_keep_reg     <= keep;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= fwd_data;
        end
    end

    mmed_ram #(
        .AW (CTRL_AW),
        .DW (DATA_W)
    ) u_ctrl_ram (
        .clk   (clk),
        .we    (ctrl_we),
        .waddr (ctrl_waddr),
        .wdata (ctrl_wdata),
        .re    (accept),
        .raddr (ctrl_raddr),
        .rdata (ctrl_rdata)
    );

    mmed_ram #(
        .AW (PROG_AW),
        .DW (DATA_W)
    ) u_prog_ram (
        .clk   (clk),
        .we    (prog_we),
        .waddr (prog_waddr),
        .wdata (prog_wdata),
        .re    (accept),
        .raddr (ch0),
        .rdata (prog_rdata)
    );

endmodule

// ===== rtl/mmed_serializer.sv =====
module mmed_serializer
    import mmed_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       msg_valid,
    output logic       msg_ready,
    input  msg_t       msg,
    output logic       valid,
    input  logic       ready,
    output logic [7:0] midi_byte,
    output logic       last_byte
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    msg_t       msg_reg;
    logic       load;

    assign last_byte = msg_reg.three ? (idx_reg == 2'd2) : (idx_reg == 2'd1);
    assign valid     = valid_reg;
    assign msg_ready = !valid_reg || (ready && last_byte);
    assign load      = msg_valid && msg_ready;

    always_comb
    begin
        case (idx_reg)
            2'd0:    midi_byte = msg_reg.status;
            2'd1:    midi_byte = msg_reg.data1;
            default: midi_byte = msg_reg.data2;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (msg_ready)
        begin
            valid_next = msg_valid;
            idx_next   = 2'd0;
        end
        else if (ready)
        begin
            // advance to the next word of the message
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            msg_reg <= msg;
        end
    end

endmodule

// ===== rtl/midi_message_encoder_with_dedup.sv =====
// Channel  Dir  Word contents
// -------  ---  ------------------------------------------
// req      in   kind[1:0], channel[7:0], number[7:0], value[7:0]
// tx       out  midi_byte[7:0], last_byte
//
// A request is read from the cache memory in the cycle it is taken and decided
// in the cycle after; its message then leaves one word per cycle while tx.ready
// is high, three words for a three-word message, two for program change.
// The output word rate sets the throughput. After reset a sweep clears both
// caches to 0xFF with req.ready low. A stall on tx holds the current word and,
// once the staging register is full, holds req.ready low.
module midi_message_encoder_with_dedup
    import mmed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    midi_req_if.sink    req,
    midi_byte_if.source tx
);

    logic msg_valid;
    logic msg_ready;
    msg_t msg;
    logic clearing;

    mmed_lookup u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .kind      (req.kind),
        .channel   (req.channel),
        .number    (req.number),
        .value     (req.value),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .clearing  (clearing)
    );

    mmed_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .valid     (tx.valid),
        .ready     (tx.ready),
        .midi_byte (tx.midi_byte),
        .last_byte (tx.last_byte)
    );

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req.ready)
        else $error("request taken during cache clear");

    a_no_output_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !tx.valid)
        else $error("output word during cache clear");

    a_msg_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready |=> tx.valid)
        else $error("message handed over but no output word");

    a_msg_continues: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.ready && !tx.last_byte |=> tx.valid)
        else $error("message cut short");

endmodule
